// ----- rtl/core/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, op codes, pipeline lane type and clamp helper for the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DW    = 16;             // data width
  localparam int FB    = 12;             // fraction bits
  localparam int PW    = 2 * DW;         // product width
  localparam int QW    = DW + 1;         // quotient bits, one per cell
  localparam int NCELL = QW;
  localparam int IW    = $clog2(QW);     // cell index width
  localparam int CW    = PW + FB + QW + 1;
  localparam int RW    = PW + 2;         // root trial width
  localparam int MW    = PW + 1;         // clamp input width

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [DW-1:0]    fast_re;
    logic [DW-1:0]    fast_im;
    logic [1:0]       fast_cmp;
    logic             fast_sat;
    logic             neg_re;
    logic             neg_im;
    logic [PW-1:0]    k;
    logic [PW+FB-1:0] d_re;
    logic [PW+FB-1:0] d_im;
    logic [QW-1:0]    q_re;
    logic [QW-1:0]    q_im;
    logic             ovf_re;
    logic             ovf_im;
    logic [PW-1:0]    rem;
    logic [DW-1:0]    root;
  } lane_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } sat_t;

  function automatic sat_t clamp(input logic neg, input logic [MW-1:0] mag,
                                 input logic ovf);
    sat_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (ovf || (mag > MW'({1'b0, {(DW-1){1'b1}}}))) begin
        r.sat = 1'b1;
        r.val = {1'b0, {(DW-1){1'b1}}};
      end else begin
        r.val = mag[DW-1:0];
      end
    end else begin
      if (ovf || (mag > (MW'(1) << (DW-1)))) begin
        r.sat = 1'b1;
        r.val = {1'b1, {(DW-1){1'b0}}};
      end else begin
        r.val = DW'(MW'(0) - mag);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Input register, product stage and sum stage; seeds the cell chain.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [2:0]                op_i,
  input  logic [cau_pkg::DW-1:0]    a_re_i,
  input  logic [cau_pkg::DW-1:0]    a_im_i,
  input  logic [cau_pkg::DW-1:0]    b_re_i,
  input  logic [cau_pkg::DW-1:0]    b_im_i,
  output cau_pkg::lane_t            lane_o
);

  localparam int DW = cau_pkg::DW;
  localparam int PW = cau_pkg::PW;
  localparam int FB = cau_pkg::FB;
  localparam int MW = cau_pkg::MW;

  // stage A
  logic                 va_q;
  cau_pkg::op_e         opa_q;
  logic [DW-1:0]        ar_q, ai_q, br_q, bi_q;

  // stage B
  logic                 vb_q;
  cau_pkg::op_e         opb_q;
  logic [DW-1:0]        arb_q, aib_q, brb_q, bib_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0] s_ar_q, s_ai_q, s_br_q, s_bi_q;

  // stage C
  logic [PW:0]          mre, mim, dre, dim;
  logic [PW-1:0]        k, ma;
  logic [PW-1:0]        mre_mag, mim_mag, dre_mag, dim_mag;
  logic [DW:0]          sre, sim, sre_mag, sim_mag;
  cau_pkg::sat_t        c_re, c_im;
  cau_pkg::lane_t       lane_d, lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      opa_q  <= cau_pkg::OP_ADD;
      ar_q   <= '0;
      ai_q   <= '0;
      br_q   <= '0;
      bi_q   <= '0;
      vb_q   <= 1'b0;
      opb_q  <= cau_pkg::OP_ADD;
      arb_q  <= '0;
      aib_q  <= '0;
      brb_q  <= '0;
      bib_q  <= '0;
      p_rr_q <= '0;
      p_ii_q <= '0;
      p_ri_q <= '0;
      p_ir_q <= '0;
      s_ar_q <= '0;
      s_ai_q <= '0;
      s_br_q <= '0;
      s_bi_q <= '0;
      lane_q <= '0;
    end else begin
      va_q   <= start;
      opa_q  <= cau_pkg::op_e'(op_i);
      ar_q   <= a_re_i;
      ai_q   <= a_im_i;
      br_q   <= b_re_i;
      bi_q   <= b_im_i;
      vb_q   <= va_q;
      opb_q  <= opa_q;
      arb_q  <= ar_q;
      aib_q  <= ai_q;
      brb_q  <= br_q;
      bib_q  <= bi_q;
      p_rr_q <= $signed(ar_q) * $signed(br_q);
      p_ii_q <= $signed(ai_q) * $signed(bi_q);
      p_ri_q <= $signed(ar_q) * $signed(bi_q);
      p_ir_q <= $signed(ai_q) * $signed(br_q);
      s_ar_q <= $signed(ar_q) * $signed(ar_q);
      s_ai_q <= $signed(ai_q) * $signed(ai_q);
      s_br_q <= $signed(br_q) * $signed(br_q);
      s_bi_q <= $signed(bi_q) * $signed(bi_q);
      lane_q <= lane_d;
    end
  end

  always_comb begin
    mre = {p_rr_q[PW-1], p_rr_q} - {p_ii_q[PW-1], p_ii_q};
    mim = {p_ri_q[PW-1], p_ri_q} + {p_ir_q[PW-1], p_ir_q};
    dre = {p_rr_q[PW-1], p_rr_q} + {p_ii_q[PW-1], p_ii_q};
    dim = {p_ir_q[PW-1], p_ir_q} - {p_ri_q[PW-1], p_ri_q};
    k   = s_br_q + s_bi_q;
    ma  = s_ar_q + s_ai_q;

    mre_mag = mre[PW] ? PW'((PW+1)'(0) - mre) : mre[PW-1:0];
    mim_mag = mim[PW] ? PW'((PW+1)'(0) - mim) : mim[PW-1:0];
    dre_mag = dre[PW] ? PW'((PW+1)'(0) - dre) : dre[PW-1:0];
    dim_mag = dim[PW] ? PW'((PW+1)'(0) - dim) : dim[PW-1:0];

    if (opb_q == cau_pkg::OP_SUB) begin
      sre = {arb_q[DW-1], arb_q} - {brb_q[DW-1], brb_q};
      sim = {aib_q[DW-1], aib_q} - {bib_q[DW-1], bib_q};
    end else begin
      sre = {arb_q[DW-1], arb_q} + {brb_q[DW-1], brb_q};
      sim = {aib_q[DW-1], aib_q} + {bib_q[DW-1], bib_q};
    end
    sre_mag = sre[DW] ? ((DW+1)'(0) - sre) : sre;
    sim_mag = sim[DW] ? ((DW+1)'(0) - sim) : sim;

    c_re = '0;
    c_im = '0;
    lane_d = '0;
    lane_d.valid = vb_q;
    lane_d.op    = opb_q;

    unique case (opb_q)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        c_re = cau_pkg::clamp(sre[DW], MW'(sre_mag), 1'b0);
        c_im = cau_pkg::clamp(sim[DW], MW'(sim_mag), 1'b0);
      end
      cau_pkg::OP_MUL: begin
        c_re = cau_pkg::clamp(mre[PW] && ((mre_mag >> FB) != '0),
                              MW'(mre_mag >> FB), 1'b0);
        c_im = cau_pkg::clamp(mim[PW] && ((mim_mag >> FB) != '0),
                              MW'(mim_mag >> FB), 1'b0);
      end
      cau_pkg::OP_CMP: begin
        lane_d.fast_cmp = (ma < k) ? cau_pkg::CMP_LT :
                          ((ma == k) ? cau_pkg::CMP_EQ : cau_pkg::CMP_GT);
      end
      default: begin
      end
    endcase

    lane_d.fast_re  = c_re.val;
    lane_d.fast_im  = c_im.val;
    lane_d.fast_sat = c_re.sat | c_im.sat;
    lane_d.neg_re   = dre[PW];
    lane_d.neg_im   = dim[PW];
    lane_d.k        = k;
    lane_d.d_re     = {dre_mag, {FB{1'b0}}};
    lane_d.d_im     = {dim_mag, {FB{1'b0}}};
    lane_d.rem      = ma;
  end

  assign lane_o = lane_q;

endmodule

// ----- rtl/core/cau_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_cell
// One quotient bit for both divide lanes and one root bit per cycle.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [cau_pkg::IW-1:0] idx_i,
  input  cau_pkg::lane_t         lane_i,
  output cau_pkg::lane_t         lane_o
);

  localparam int PW = cau_pkg::PW;
  localparam int FB = cau_pkg::FB;
  localparam int QW = cau_pkg::QW;
  localparam int DW = cau_pkg::DW;
  localparam int CW = cau_pkg::CW;
  localparam int RW = cau_pkg::RW;
  localparam int IW = cau_pkg::IW;

  logic [CW-1:0]  kd, kd1, dre, dim;
  logic [RW-1:0]  trial, remw, rootn;
  cau_pkg::lane_t lane_d, lane_q;

  always_comb begin
    lane_d = lane_i;
    kd  = CW'(lane_i.k) << idx_i;
    kd1 = kd << 1;
    dre = CW'(lane_i.d_re);
    dim = CW'(lane_i.d_im);

    lane_d.ovf_re = lane_i.ovf_re | (dre >= kd1);
    lane_d.ovf_im = lane_i.ovf_im | (dim >= kd1);
    if (dre >= kd) begin
      lane_d.d_re = (PW+FB)'(dre - kd);
      lane_d.q_re = lane_i.q_re | (QW'(1) << idx_i);
    end
    if (dim >= kd) begin
      lane_d.d_im = (PW+FB)'(dim - kd);
      lane_d.q_im = lane_i.q_im | (QW'(1) << idx_i);
    end

    trial = (RW'(lane_i.root) << ((IW+1)'(idx_i) + (IW+1)'(1)))
          + (RW'(1) << ((IW+1)'(idx_i) << 1));
    remw  = RW'(lane_i.rem);
    rootn = RW'(lane_i.root) | (RW'(1) << idx_i);
    if (remw >= trial) begin
      lane_d.rem  = PW'(remw - trial);
      lane_d.root = rootn[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ----- rtl/core/cau_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Final clamp, result select and output register.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cau_pkg::lane_t         lane_i,
  output logic                   done_o,
  output logic [cau_pkg::DW-1:0] res_re_o,
  output logic [cau_pkg::DW-1:0] res_im_o,
  output logic [1:0]             cmp_o,
  output logic                   div_by_zero_o,
  output logic                   saturated_o
);

  localparam int DW = cau_pkg::DW;
  localparam int MW = cau_pkg::MW;

  cau_pkg::sat_t c_re, c_im;
  logic          done_d, done_q;
  logic [DW-1:0] re_d, re_q, im_d, im_q;
  logic [1:0]    cmp_d, cmp_q;
  logic          dz_d, dz_q, sat_d, sat_q;

  always_comb begin
    c_re   = '0;
    c_im   = '0;
    done_d = lane_i.valid;
    re_d   = '0;
    im_d   = '0;
    cmp_d  = cau_pkg::CMP_LT;
    dz_d   = 1'b0;
    sat_d  = 1'b0;
    unique case (lane_i.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        re_d  = lane_i.fast_re;
        im_d  = lane_i.fast_im;
        sat_d = lane_i.fast_sat;
      end
      cau_pkg::OP_DIV: begin
        if (lane_i.k == '0) begin
          dz_d = 1'b1;
        end else begin
          c_re = cau_pkg::clamp(lane_i.neg_re && (lane_i.ovf_re || lane_i.q_re != '0),
                                MW'(lane_i.q_re), lane_i.ovf_re);
          c_im = cau_pkg::clamp(lane_i.neg_im && (lane_i.ovf_im || lane_i.q_im != '0),
                                MW'(lane_i.q_im), lane_i.ovf_im);
          re_d  = c_re.val;
          im_d  = c_im.val;
          sat_d = c_re.sat | c_im.sat;
        end
      end
      cau_pkg::OP_MAG: begin
        c_re  = cau_pkg::clamp(1'b0, MW'(lane_i.root), 1'b0);
        re_d  = c_re.val;
        sat_d = c_re.sat;
      end
      cau_pkg::OP_CMP: begin
        cmp_d = lane_i.fast_cmp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      re_q   <= '0;
      im_q   <= '0;
      cmp_q  <= cau_pkg::CMP_LT;
      dz_q   <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      re_q   <= re_d;
      im_q   <= im_d;
      cmp_q  <= cmp_d;
      dz_q   <= dz_d;
      sat_q  <= sat_d;
    end
  end

  assign done_o        = done_q;
  assign res_re_o      = re_q;
  assign res_im_o      = im_q;
  assign cmp_o         = cmp_q;
  assign div_by_zero_o = dz_q;
  assign saturated_o   = sat_q;

endmodule

// ----- rtl/core/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Add, subtract, multiply, divide, magnitude and magnitude compare of
// complex Q4.12 operands, pipelined through a chain of shift-subtract cells.
//
//   channel  | handshake       | payload
//   ---------+-----------------+--------------------------------------------
//   command  | start / busy    | op_i, a_re_i, a_im_i, b_re_i, b_im_i
//   result   | done_o (strobe) | res_re_o, res_im_o, cmp_o, div_by_zero_o,
//            |                 | saturated_o
//
// One transaction per cycle; busy is always low.
// Pipeline: 3 front stages (input, products, sums), 17 cells
// (one quotient/root bit each), 1 output stage.
// Reset empties the pipeline; no result is pending after it.
// Results leave on a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             op_i,
  input  logic [cau_pkg::DW-1:0] a_re_i,
  input  logic [cau_pkg::DW-1:0] a_im_i,
  input  logic [cau_pkg::DW-1:0] b_re_i,
  input  logic [cau_pkg::DW-1:0] b_im_i,
  output logic                   done_o,
  output logic [cau_pkg::DW-1:0] res_re_o,
  output logic [cau_pkg::DW-1:0] res_im_o,
  output logic [1:0]             cmp_o,
  output logic                   div_by_zero_o,
  output logic                   saturated_o
);

  cau_pkg::lane_t chain [cau_pkg::NCELL+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .lane_o (chain[0])
  );

  for (genvar g = 0; g < cau_pkg::NCELL; g++) begin : g_cell
    cau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (cau_pkg::IW'(cau_pkg::NCELL - 1 - g)),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  cau_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lane_i        (chain[cau_pkg::NCELL]),
    .done_o        (done_o),
    .res_re_o      (res_re_o),
    .res_im_o      (res_im_o),
    .cmp_o         (cmp_o),
    .div_by_zero_o (div_by_zero_o),
    .saturated_o   (saturated_o)
  );

endmodule

// ----- bench/complex_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives directed and random complex operand pairs through every op code,
// predicts each result in fixed point and compares it field by field with
// the strobed output, under several sender idling phases.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int LATENCY = 21;
  localparam logic [2:0] OP_NONE6 = 3'd6;
  localparam logic [2:0] OP_NONE7 = 3'd7;

  typedef struct {
    logic [2:0]    op;
    logic [DW-1:0] a_re, a_im, b_re, b_im;
  } cmd_t;

  typedef struct {
    logic [DW-1:0] re, im;
    logic [1:0]    cmp;
    logic          dz, sat;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] op_i = '0;
  logic [DW-1:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic done_o;
  logic [DW-1:0] res_re_o, res_im_o;
  logic [1:0] cmp_o;
  logic div_by_zero_o, saturated_o;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   error_count = 0;
  int   idle_pct = 0;
  bit   hold_off = 1'b0;

  complex_arithmetic_unit DUT (.*);

  always #4 clk_i = ~clk_i;

  // saturate a signed wide value to DW bits
  function automatic logic [DW-1:0] sat_fit(input longint v, inout logic sat);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -(longint'(1) <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // truncating division toward zero of n*2^FB by k
  function automatic longint scaled_quot(input longint n, input longint k);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m <<< FB) / k;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint isqrt(input longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) <<< b)) * (r + (longint'(1) <<< b)) <= x)
        r = r + (longint'(1) <<< b);
    return r;
  endfunction

  function automatic res_t compute_result(input cmd_t c);
    res_t   r;
    longint ar, ai, br, bi, x, y, k, ma, mb;
    ar = longint'($signed(c.a_re));
    ai = longint'($signed(c.a_im));
    br = longint'($signed(c.b_re));
    bi = longint'($signed(c.b_im));
    r = '{re: '0, im: '0, cmp: CMP_LT, dz: 1'b0, sat: 1'b0};
    case (c.op)
      OP_ADD: begin
        r.re = sat_fit(ar + br, r.sat);
        r.im = sat_fit(ai + bi, r.sat);
      end
      OP_SUB: begin
        r.re = sat_fit(ar - br, r.sat);
        r.im = sat_fit(ai - bi, r.sat);
      end
      OP_MUL: begin
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        x = (x < 0) ? -((-x) >>> FB) : (x >>> FB);
        y = (y < 0) ? -((-y) >>> FB) : (y >>> FB);
        r.re = sat_fit(x, r.sat);
        r.im = sat_fit(y, r.sat);
      end
      OP_DIV: begin
        k = br * br + bi * bi;
        if (k == 0) r.dz = 1'b1;
        else begin
          r.re = sat_fit(scaled_quot(ar * br + ai * bi, k), r.sat);
          r.im = sat_fit(scaled_quot(ai * br - ar * bi, k), r.sat);
        end
      end
      OP_MAG: r.re = sat_fit(isqrt(ar * ar + ai * ai), r.sat);
      OP_CMP: begin
        ma = ar * ar + ai * ai;
        mb = br * br + bi * bi;
        r.cmp = (ma < mb) ? CMP_LT : ((ma == mb) ? CMP_EQ : CMP_GT);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [DW-1:0] ar, ai, br, bi);
    cmd_t c;
    c = '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    pending_cmds.push_back(c);
  endtask

  function automatic logic [DW-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return DW'($urandom_range(0, 8)) - DW'(4);
      4: return DW'(1) << FB;
      default: return DW'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(compute_result('{op: op_i, a_re: a_re_i,
          a_im: a_im_i, b_re: b_re_i, b_im: b_im_i}));
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && !hold_off &&
            $urandom_range(0, 99) >= idle_pct) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          start  <= 1'b1;
          op_i   <= c.op;
          a_re_i <= c.a_re;
          a_im_i <= c.a_im;
          b_re_i <= c.b_re;
          b_im_i <= c.b_im;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        error_count++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (res_re_o !== e.re) report_mismatch("res_re", res_re_o, e.re);
        if (res_im_o !== e.im) report_mismatch("res_im", res_im_o, e.im);
        if (cmp_o !== e.cmp) report_mismatch("cmp", DW'(cmp_o), DW'(e.cmp));
        if (div_by_zero_o !== e.dz)
          report_mismatch("div_by_zero", DW'(div_by_zero_o), DW'(e.dz));
        if (saturated_o !== e.sat)
          report_mismatch("saturated", DW'(saturated_o), DW'(e.sat));
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic wait_in_flight();
    while (start || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [DW-1:0] mx, mn, one;
    mx  = {1'b0, {(DW-1){1'b1}}};
    mn  = {1'b1, {(DW-1){1'b0}}};
    one = DW'(1) << FB;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_cmd(OP_ADD, mx, mx, mx, mx);
    add_cmd(OP_ADD, mn, mn, mn, mn);
    add_cmd(OP_SUB, mn, mx, mx, mn);
    add_cmd(OP_SUB, one, '0, one, '0);
    add_cmd(OP_MUL, mn, mn, mn, mn);
    add_cmd(OP_MUL, one, one, one, -one);
    add_cmd(OP_MUL, DW'(1), '0, -DW'(1), '0);
    add_cmd(OP_DIV, one, one, '0, '0);
    add_cmd(OP_DIV, mx, mn, DW'(1), '0);
    add_cmd(OP_DIV, one, '0, one, one);
    add_cmd(OP_DIV, -DW'(1), '0, mx, '0);
    add_cmd(OP_MAG, mn, mn, '0, '0);
    add_cmd(OP_MAG, DW'(3) << FB, DW'(4) << FB, '0, '0);
    add_cmd(OP_MAG, '0, '0, '0, '0);
    add_cmd(OP_CMP, one, '0, '0, -one);
    add_cmd(OP_CMP, mn, '0, mx, mx);
    add_cmd(OP_CMP, mx, mx, one, '0);
    add_cmd(OP_NONE6, mx, mn, one, one);
    add_cmd(OP_NONE7, mn, mx, one, one);
    wait_drained();

    // random phases with varying idle rates; in one, pause until drained, then resume
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : ((ph == 3) ? 25 : 0);
      for (int i = 0; i < 335; i++)
        add_cmd(3'($urandom_range(0, 7)), rand_val(), rand_val(), rand_val(), rand_val());
      if (ph == 2) begin
        repeat (100) @(posedge clk_i);
        hold_off = 1'b1;
        wait_in_flight();
        repeat (5) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_drained();
    end
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
